// ----- src/fcbf_pkg.sv -----
`timescale 1ns / 1ps
// shared types and constants for the flow controlled byte fifo
// no dependencies

package fcbf_pkg;

   localparam int DEFAULT_MAX_DEPTH = 4096;

   localparam int OP_W     = 2;
   localparam int BYTE_W   = 8;
   localparam int OFFSET_W = 12;
   localparam int FILL_W   = 13;
   localparam int CAP_W    = 13;
   localparam int TOTAL_W  = 64;

   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   // register index taken from the word address
   localparam logic CAP_INDEX = 1'b0;

   localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(4096);

   typedef enum logic [OP_W-1:0] {
      OP_WRITE = 2'd0,
      OP_READ  = 2'd1,
      OP_PEEK  = 2'd2,
      OP_END   = 2'd3
   } opcode_type;

endpackage

// ----- src/fcbf_store.sv -----
`timescale 1ns / 1ps
// byte store: one write port, one read port with registered read data
// depends on fcbf_pkg

module fcbf_store
   import fcbf_pkg::*;
#(
   parameter int DEPTH = DEFAULT_MAX_DEPTH,
   localparam int ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [BYTE_W-1:0] wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [BYTE_W-1:0] rd_data
);

   logic [BYTE_W-1:0] store_mem [DEPTH];
   logic [BYTE_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= store_mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- src/flow_controlled_byte_fifo_top.sv -----
`timescale 1ns / 1ps
// byte fifo with capacity limit, end-of-input mark and running totals
// depends on fcbf_pkg and fcbf_store

// One request is taken every clock cycle while the response is not stalled,
// and its response appears registered in the next cycle, as the byte store,
// whose single read port serves both pop and peek, has registered read data.
// A new request is taken whenever the response register is empty or being
// drained in the same cycle. Pointers, fill count, flags and totals live in
// flip-flops and are updated at the edge that takes the request; the store is
// written at the tail on an accepted write. The capacity register (byte
// address 0) sets the most bytes held at once, saturated at MAX_DEPTH, and may
// be lowered below the current fill without losing data.

module flow_controlled_byte_fifo_top
   import fcbf_pkg::*;
#(
   parameter int MAX_DEPTH = DEFAULT_MAX_DEPTH
) (
   input  logic                  clock,
   input  logic                  reset,

   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [OP_W-1:0]       req_opcode,
   input  logic [BYTE_W-1:0]     req_write_byte,
   input  logic [OFFSET_W-1:0]   req_peek_offset,

   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic                  rsp_done_res,
   output logic [BYTE_W-1:0]     rsp_out_byte,
   output logic [FILL_W-1:0]     rsp_fill_count,
   output logic [FILL_W-1:0]     rsp_space_left,
   output logic                  rsp_input_closed,
   output logic                  rsp_at_eof,
   output logic [TOTAL_W-1:0]    rsp_total_written,
   output logic [TOTAL_W-1:0]    rsp_total_read,

   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic                  pready
);

   localparam int ADDR_W = $clog2(MAX_DEPTH);
   localparam int CNT_W  = $clog2(MAX_DEPTH + 1);
   localparam int CMP_W  = (CNT_W > CAP_W) ? CNT_W : CAP_W;

   localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(MAX_DEPTH - 1);
   localparam logic [ADDR_W:0]   DEPTH_SUM = (ADDR_W + 1)'(MAX_DEPTH);
   localparam logic [CMP_W-1:0]  DEPTH_CMP = CMP_W'(MAX_DEPTH);

   // control and payload registers
   logic [CAP_W-1:0]   cap_ff;
   logic [ADDR_W-1:0]  head_ff, head_in;
   logic [ADDR_W-1:0]  tail_ff, tail_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic               ended_ff, ended_in;
   logic [TOTAL_W-1:0] wr_total_ff, wr_total_in;
   logic [TOTAL_W-1:0] rd_total_ff, rd_total_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic               done_ff, done_in;
   logic               byte_sel_ff, byte_sel_in;
   logic [FILL_W-1:0]  space_ff, space_in;

   logic               req_take;
   logic               csr_write;
   opcode_type         op;
   logic [CMP_W-1:0]   cap_eff;
   logic [CMP_W-1:0]   count_cmp;
   logic [CMP_W-1:0]   count_in_cmp;
   logic [CMP_W-1:0]   offset_cmp;
   logic               can_write;
   logic               can_read;
   logic               can_peek;
   logic [ADDR_W:0]    peek_sum;
   logic [ADDR_W-1:0]  peek_addr;
   logic               wr_en;
   logic               rd_en;
   logic [ADDR_W-1:0]  rd_addr;
   logic [BYTE_W-1:0]  rd_data;

   // configuration port
   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite && pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff <= CAP_RESET;
      end else if (csr_write && paddr[2] == CAP_INDEX) begin
         cap_ff <= pwdata[CAP_W-1:0];
      end
   end

   always_comb begin
      prdata = '0;
      if (paddr[2] == CAP_INDEX) begin
         prdata = CSR_DATA_W'(cap_ff);
      end
   end

   // request decode
   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign req_take  = req_valid && req_ready;
   assign op        = opcode_type'(req_opcode);

   assign cap_eff    = (CMP_W'(cap_ff) > DEPTH_CMP) ? DEPTH_CMP : CMP_W'(cap_ff);
   assign count_cmp  = CMP_W'(count_ff);
   assign offset_cmp = CMP_W'(req_peek_offset);

   assign can_write = !ended_ff && (count_cmp < cap_eff);
   assign can_read  = (count_ff != '0);
   assign can_peek  = (offset_cmp < count_cmp);

   // head plus offset, wrapped at the store depth
   assign peek_sum  = {1'b0, head_ff} + {1'b0, ADDR_W'(req_peek_offset)};
   assign peek_addr = (peek_sum >= DEPTH_SUM) ? ADDR_W'(peek_sum - DEPTH_SUM)
                                              : peek_sum[ADDR_W-1:0];

   // next state
   always_comb begin
      head_in     = head_ff;
      tail_in     = tail_ff;
      count_in    = count_ff;
      ended_in    = ended_ff;
      wr_total_in = wr_total_ff;
      rd_total_in = rd_total_ff;
      done_in     = 1'b0;
      byte_sel_in = 1'b0;
      wr_en       = 1'b0;
      rd_en       = 1'b0;
      rd_addr     = head_ff;
      case (op)
         OP_WRITE: begin
            if (can_write) begin
               wr_en       = req_take;
               tail_in     = (tail_ff == LAST_ADDR) ? '0 : tail_ff + 1'b1;
               count_in    = count_ff + 1'b1;
               wr_total_in = wr_total_ff + 1'b1;
               done_in     = 1'b1;
            end
         end
         OP_READ: begin
            if (can_read) begin
               rd_en       = req_take;
               head_in     = (head_ff == LAST_ADDR) ? '0 : head_ff + 1'b1;
               count_in    = count_ff - 1'b1;
               rd_total_in = rd_total_ff + 1'b1;
               done_in     = 1'b1;
               byte_sel_in = 1'b1;
            end
         end
         OP_PEEK: begin
            if (can_peek) begin
               rd_en       = req_take;
               rd_addr     = peek_addr;
               done_in     = 1'b1;
               byte_sel_in = 1'b1;
            end
         end
         OP_END: begin
            ended_in = 1'b1;
         end
         default: begin
            ended_in = ended_ff;
         end
      endcase
   end

   assign count_in_cmp = CMP_W'(count_in);
   assign space_in     = (cap_eff > count_in_cmp) ? FILL_W'(cap_eff - count_in_cmp) : '0;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (req_take) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff      <= '0;
         tail_ff      <= '0;
         count_ff     <= '0;
         ended_ff     <= 1'b0;
         wr_total_ff  <= '0;
         rd_total_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (req_take) begin
            head_ff     <= head_in;
            tail_ff     <= tail_in;
            count_ff    <= count_in;
            ended_ff    <= ended_in;
            wr_total_ff <= wr_total_in;
            rd_total_ff <= rd_total_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         done_ff     <= done_in;
         byte_sel_ff <= byte_sel_in;
         space_ff    <= space_in;
      end
   end

   fcbf_store #(
      .DEPTH   (MAX_DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (tail_ff),
      .wr_data (req_write_byte),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // response; state only moves on a new request, so it holds while stalled
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_done_res      = done_ff;
   assign rsp_out_byte      = byte_sel_ff ? rd_data : '0;
   assign rsp_fill_count    = FILL_W'(count_ff);
   assign rsp_space_left    = space_ff;
   assign rsp_input_closed  = ended_ff;
   assign rsp_at_eof        = ended_ff && (count_ff == '0);
   assign rsp_total_written = wr_total_ff;
   assign rsp_total_read    = rd_total_ff;

endmodule

// ----- sim/tb_flow_controlled_byte_fifo_top.sv -----
`timescale 1ns / 1ps
// self-checking testbench for flow_controlled_byte_fifo_top: a directed table and random
// phases, checked against a shadow fifo kept in the testbench, typed table rows in part against the table
// depends on fcbf_pkg and flow_controlled_byte_fifo_top

module tb_flow_controlled_byte_fifo_top;
   import fcbf_pkg::*;

   localparam int DEPTH = DEFAULT_MAX_DEPTH;
   localparam int HOLD_CYCLES = 400;
   localparam longint TIMEOUT_NS = 64'd50_000_000;
   localparam logic [CSR_ADDR_W-1:0] CAP_ADDR = CSR_ADDR_W'({CAP_INDEX, 2'b00});

   typedef struct packed {
      logic               done;
      logic [BYTE_W-1:0]  obyte;
      logic [FILL_W-1:0]  fill;
      logic [FILL_W-1:0]  space;
      logic               closed;
      logic               eof;
      logic [TOTAL_W-1:0] total_wr;
      logic [TOTAL_W-1:0] total_rd;
   } fifo_status_type;

   typedef struct packed {
      bit                 cfg;
      logic [CAP_W-1:0]   cap;
      opcode_type         op;
      logic [BYTE_W-1:0]  wbyte;
      logic [OFFSET_W-1:0] off;
      bit                 typed;
      bit                 done;
      logic [BYTE_W-1:0]  obyte;
      int                 fill;
      int                 space;
   } stim_row_type;

   logic                  clock;
   logic                  reset;
   logic                  req_valid;
   logic                  req_ready;
   logic [OP_W-1:0]       req_opcode;
   logic [BYTE_W-1:0]     req_write_byte;
   logic [OFFSET_W-1:0]   req_peek_offset;
   logic                  rsp_valid;
   logic                  rsp_ready;
   logic                  rsp_done_res;
   logic [BYTE_W-1:0]     rsp_out_byte;
   logic [FILL_W-1:0]     rsp_fill_count;
   logic [FILL_W-1:0]     rsp_space_left;
   logic                  rsp_input_closed;
   logic                  rsp_at_eof;
   logic [TOTAL_W-1:0]    rsp_total_written;
   logic [TOTAL_W-1:0]    rsp_total_read;
   logic                  psel;
   logic                  penable;
   logic                  pwrite;
   logic [CSR_ADDR_W-1:0] paddr;
   logic [CSR_DATA_W-1:0] pwdata;
   logic [CSR_DATA_W-1:0] prdata;
   logic                  pready;

   flow_controlled_byte_fifo_top dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_opcode        (req_opcode),
      .req_write_byte    (req_write_byte),
      .req_peek_offset   (req_peek_offset),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_done_res      (rsp_done_res),
      .rsp_out_byte      (rsp_out_byte),
      .rsp_fill_count    (rsp_fill_count),
      .rsp_space_left    (rsp_space_left),
      .rsp_input_closed  (rsp_input_closed),
      .rsp_at_eof        (rsp_at_eof),
      .rsp_total_written (rsp_total_written),
      .rsp_total_read    (rsp_total_read),
      .psel              (psel),
      .penable           (penable),
      .pwrite            (pwrite),
      .paddr             (paddr),
      .pwdata            (pwdata),
      .prdata            (prdata),
      .pready            (pready)
   );

   // shadow copy of the fifo
   logic [BYTE_W-1:0]   shadow_store [DEPTH];
   logic [OFFSET_W-1:0] shadow_head;
   logic [OFFSET_W-1:0] shadow_tail;
   logic [FILL_W-1:0]   shadow_fill;
   logic                shadow_closed;
   logic [TOTAL_W-1:0]  shadow_written;
   logic [TOTAL_W-1:0]  shadow_read;
   logic [CAP_W-1:0]    cap_setting;

   fifo_status_type pending_status [$];
   int  mismatch_count = 0;
   bit  steady = 0;
   bit  hold_request = 0;

   // cfg, cap, op, byte, offset, typed, done, out byte, fill, space
   stim_row_type directed_rows [0:27] = '{
      '{1'b0, 13'd0,    OP_READ,  8'h00, 12'h000, 1'b1, 1'b0, 8'h00, 0, 4096},
      '{1'b0, 13'd0,    OP_PEEK,  8'h00, 12'h000, 1'b1, 1'b0, 8'h00, 0, 4096},
      '{1'b0, 13'd0,    OP_WRITE, 8'h00, 12'h000, 1'b1, 1'b1, 8'h00, 1, 4095},
      '{1'b0, 13'd0,    OP_WRITE, 8'hFF, 12'hFFF, 1'b1, 1'b1, 8'h00, 2, 4094},
      '{1'b0, 13'd0,    OP_PEEK,  8'h00, 12'h000, 1'b1, 1'b1, 8'h00, 2, 4094},
      '{1'b0, 13'd0,    OP_PEEK,  8'hFF, 12'h001, 1'b1, 1'b1, 8'hFF, 2, 4094},
      '{1'b0, 13'd0,    OP_PEEK,  8'h00, 12'h002, 1'b1, 1'b0, 8'h00, 2, 4094},
      '{1'b0, 13'd0,    OP_PEEK,  8'h00, 12'hFFF, 1'b1, 1'b0, 8'h00, 2, 4094},
      '{1'b0, 13'd0,    OP_READ,  8'hFF, 12'hFFF, 1'b1, 1'b1, 8'h00, 1, 4095},
      '{1'b0, 13'd0,    OP_READ,  8'h00, 12'h000, 1'b1, 1'b1, 8'hFF, 0, 4096},
      '{1'b1, 13'd3,    OP_WRITE, 8'h00, 12'h000, 1'b0, 1'b0, 8'h00, 0, 0},
      '{1'b0, 13'd0,    OP_WRITE, 8'hA5, 12'h000, 1'b0, 1'b0, 8'h00, 0, 0},
      '{1'b0, 13'd0,    OP_WRITE, 8'h5A, 12'h555, 1'b0, 1'b0, 8'h00, 0, 0},
      '{1'b0, 13'd0,    OP_WRITE, 8'h3C, 12'hAAA, 1'b0, 1'b0, 8'h00, 0, 0},
      '{1'b0, 13'd0,    OP_WRITE, 8'hC3, 12'h000, 1'b1, 1'b0, 8'h00, 3, 0},
      '{1'b1, 13'd1,    OP_WRITE, 8'h00, 12'h000, 1'b0, 1'b0, 8'h00, 0, 0},
      '{1'b0, 13'd0,    OP_WRITE, 8'h77, 12'h000, 1'b1, 1'b0, 8'h00, 3, 0},
      '{1'b0, 13'd0,    OP_READ,  8'h00, 12'h000, 1'b1, 1'b1, 8'hA5, 2, 0},
      '{1'b0, 13'd0,    OP_READ,  8'h00, 12'h000, 1'b1, 1'b1, 8'h5A, 1, 0},
      '{1'b0, 13'd0,    OP_WRITE, 8'h11, 12'h000, 1'b1, 1'b0, 8'h00, 1, 0},
      '{1'b0, 13'd0,    OP_READ,  8'h00, 12'h000, 1'b1, 1'b1, 8'h3C, 0, 1},
      '{1'b1, 13'd0,    OP_WRITE, 8'h00, 12'h000, 1'b0, 1'b0, 8'h00, 0, 0},
      '{1'b0, 13'd0,    OP_WRITE, 8'h22, 12'h000, 1'b1, 1'b0, 8'h00, 0, 0},
      '{1'b0, 13'd0,    OP_READ,  8'h00, 12'h000, 1'b1, 1'b0, 8'h00, 0, 0},
      '{1'b1, 13'd8191, OP_WRITE, 8'h00, 12'h000, 1'b0, 1'b0, 8'h00, 0, 0},
      '{1'b0, 13'd0,    OP_WRITE, 8'h80, 12'h000, 1'b1, 1'b1, 8'h00, 1, 4095},
      '{1'b0, 13'd0,    OP_PEEK,  8'h00, 12'h000, 1'b1, 1'b1, 8'h80, 1, 4095},
      '{1'b0, 13'd0,    OP_READ,  8'h00, 12'h000, 1'b1, 1'b1, 8'h80, 0, 4096}
   };

   logic [CAP_W-1:0] phase_caps [0:13] = '{
      13'd12, 13'd1, 13'd64, 13'd0, 13'd200, 13'd2, 13'd4096,
      13'd8191, 13'd3, 13'd33, 13'd1000, 13'd7, 13'd4095, 13'd17
   };

   always #6 clock = ~clock;

   function automatic fifo_status_type predict_fifo_op(input opcode_type op,
                                                       input logic [BYTE_W-1:0] b,
                                                       input logic [OFFSET_W-1:0] off);
      fifo_status_type s;
      int limit;
      logic [OFFSET_W-1:0] pos;
      limit = (cap_setting > DEPTH) ? DEPTH : int'(cap_setting);
      s = '0;
      case (op)
         OP_WRITE: begin
            if (!shadow_closed && shadow_fill < limit) begin
               shadow_store[shadow_tail] = b;
               shadow_tail = shadow_tail + 1'b1;
               shadow_fill = shadow_fill + 1'b1;
               shadow_written = shadow_written + 1'b1;
               s.done = 1'b1;
            end
         end
         OP_READ: begin
            if (shadow_fill != 0) begin
               s.obyte = shadow_store[shadow_head];
               shadow_head = shadow_head + 1'b1;
               shadow_fill = shadow_fill - 1'b1;
               shadow_read = shadow_read + 1'b1;
               s.done = 1'b1;
            end
         end
         OP_PEEK: begin
            if (off < shadow_fill) begin
               pos = shadow_head + off;
               s.obyte = shadow_store[pos];
               s.done = 1'b1;
            end
         end
         OP_END: shadow_closed = 1'b1;
         default: ;
      endcase
      s.fill = shadow_fill;
      s.space = (limit > shadow_fill) ? FILL_W'(limit - int'(shadow_fill)) : '0;
      s.closed = shadow_closed;
      s.eof = shadow_closed && (shadow_fill == 0);
      s.total_wr = shadow_written;
      s.total_rd = shadow_read;
      return s;
   endfunction

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 45) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   function automatic int pick_stall();
      int r;
      r = $urandom_range(0, 99);
      if (r < 80) return $urandom_range(1, 3);
      if (r < 96) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   function automatic opcode_type pick_op(input int wr_pct, input bit allow_end);
      int r;
      r = $urandom_range(0, 99);
      if (allow_end && r < 5) return OP_END;
      if (r < wr_pct) return OP_WRITE;
      if (r < wr_pct + 15) return OP_PEEK;
      return OP_READ;
   endfunction

   function automatic logic [OFFSET_W-1:0] pick_offset();
      int top;
      if ($urandom_range(0, 3) == 0) return OFFSET_W'($urandom);
      top = int'(shadow_fill) + 1;
      if (top > DEPTH - 1) top = DEPTH - 1;
      return OFFSET_W'($urandom_range(0, top));
   endfunction

   task automatic compare_field(input string name, input logic [63:0] want,
                                input logic [63:0] got);
      if (want !== got) begin
         mismatch_count++;
         if (mismatch_count <= 10)
            $display("mismatch %s: expected %0h got %0h at %0t", name, want, got, $realtime);
      end
   endtask

   // called at a falling edge, returns at the falling edge after acceptance
   task automatic send_request(input opcode_type op, input logic [BYTE_W-1:0] b,
                               input logic [OFFSET_W-1:0] off, input fifo_status_type want);
      int gap;
      gap = steady ? 0 : pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_opcode <= op;
      req_write_byte <= b;
      req_peek_offset <= off;
      do @(posedge clock); while (!req_ready);
      pending_status.push_back(want);
      @(negedge clock);
   endtask

   task automatic issue(input opcode_type op, input logic [BYTE_W-1:0] b,
                        input logic [OFFSET_W-1:0] off);
      fifo_status_type want;
      want = predict_fifo_op(op, b, off);
      send_request(op, b, off, want);
   endtask

   task automatic wait_until_drained();
      req_valid <= 1'b0;
      while (pending_status.size() != 0) @(negedge clock);
      repeat (2) @(negedge clock);
   endtask

   task automatic program_capacity(input logic [CAP_W-1:0] value);
      logic [CSR_DATA_W-1:0] readback;
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= CAP_ADDR;
      pwdata <= CSR_DATA_W'(value);
      @(negedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      @(negedge clock);
      penable <= 1'b0;
      pwrite <= 1'b0;
      @(negedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      readback = prdata;
      @(negedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      cap_setting = value;
      compare_field("capacity readback", 64'(value), 64'(readback));
   endtask

   // response checker
   always @(posedge clock) begin
      fifo_status_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_status.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("unexpected response at %0t", $realtime);
         end else begin
            want = pending_status.pop_front();
            compare_field("done_res", 64'(want.done), 64'(rsp_done_res));
            compare_field("out_byte", 64'(want.obyte), 64'(rsp_out_byte));
            compare_field("fill_count", 64'(want.fill), 64'(rsp_fill_count));
            compare_field("space_left", 64'(want.space), 64'(rsp_space_left));
            compare_field("input_closed", 64'(want.closed), 64'(rsp_input_closed));
            compare_field("at_eof", 64'(want.eof), 64'(rsp_at_eof));
            compare_field("total_written", want.total_wr, rsp_total_written);
            compare_field("total_read", want.total_rd, rsp_total_read);
         end
      end
   end

   // response side back-pressure
   initial begin
      rsp_ready = 1'b0;
      @(negedge reset);
      @(negedge clock);
      forever begin
         if (hold_request) begin
            hold_request = 0;
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
         end
         rsp_ready <= 1'b1;
         repeat ($urandom_range(1, 16)) @(negedge clock);
         if (!steady) begin
            rsp_ready <= 1'b0;
            repeat (pick_stall()) @(negedge clock);
         end
      end
   end

   initial begin
      #(TIMEOUT_NS);
      $display("FAIL flow_controlled_byte_fifo_top");
      $finish;
   end

   initial begin
      fifo_status_type want;
      int wr_pct;
      clock = 1'b0;
      reset = 1'b1;
      req_valid = 1'b0;
      req_opcode = OP_WRITE;
      req_write_byte = '0;
      req_peek_offset = '0;
      psel = 1'b0;
      penable = 1'b0;
      pwrite = 1'b0;
      paddr = '0;
      pwdata = '0;
      shadow_head = '0;
      shadow_tail = '0;
      shadow_fill = '0;
      shadow_closed = 1'b0;
      shadow_written = '0;
      shadow_read = '0;
      cap_setting = CAP_RESET;

      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed table
      foreach (directed_rows[i]) begin
         if (directed_rows[i].cfg) begin
            wait_until_drained();
            program_capacity(directed_rows[i].cap);
         end else begin
            want = predict_fifo_op(directed_rows[i].op, directed_rows[i].wbyte,
                                   directed_rows[i].off);
            if (directed_rows[i].typed) begin
               want.done = directed_rows[i].done;
               want.obyte = directed_rows[i].obyte;
               want.fill = FILL_W'(directed_rows[i].fill);
               want.space = FILL_W'(directed_rows[i].space);
            end
            send_request(directed_rows[i].op, directed_rows[i].wbyte,
                         directed_rows[i].off, want);
         end
      end

      // random phases, capacity changes while idle
      for (int p = 0; p < 14; p++) begin
         wait_until_drained();
         program_capacity(phase_caps[p]);
         steady = (p == 3 || p == 6 || p == 10);
         if (p == 6) hold_request = 1;
         wr_pct = (p % 2 == 0) ? 65 : 25;
         repeat (95) issue(pick_op(wr_pct, 1'b0), BYTE_W'($urandom), pick_offset());
      end
      steady = 0;

      // end of input, then drain to eof
      wait_until_drained();
      program_capacity(13'd50);
      repeat (60) issue(pick_op(55, 1'b1), BYTE_W'($urandom), pick_offset());
      issue(OP_END, BYTE_W'($urandom), OFFSET_W'($urandom));
      issue(OP_END, BYTE_W'($urandom), OFFSET_W'($urandom));
      repeat (20) issue(pick_op(50, 1'b0), BYTE_W'($urandom), pick_offset());
      while (shadow_fill != 0) issue(OP_READ, BYTE_W'($urandom), pick_offset());
      issue(OP_READ, BYTE_W'($urandom), OFFSET_W'($urandom));
      issue(OP_PEEK, BYTE_W'($urandom), '0);
      issue(OP_WRITE, BYTE_W'($urandom), OFFSET_W'($urandom));

      wait_until_drained();
      repeat (4) @(negedge clock);
      if (mismatch_count == 0) begin
         $display("PASS flow_controlled_byte_fifo_top");
      end else begin
         $display("FAIL flow_controlled_byte_fifo_top");
      end
      $finish;
   end

endmodule
